// ===== rtl/vmap_pkg.sv =====
// Shared types, constants and helper functions of the video memory access ports.
`default_nettype none

package vmap_pkg;

  localparam int VRAM_BYTES    = 65536;
  localparam int OAM_BYTES     = 544;
  localparam int PALETTE_WORDS = 256;

  // Video and object memories are split into even and odd byte banks, one row per byte pair.
  localparam int VRAM_ROWS = VRAM_BYTES / 2;
  localparam int OAM_ROWS  = OAM_BYTES / 2;
  localparam int VROW_W    = $clog2(VRAM_ROWS);
  localparam int OROW_W    = $clog2(OAM_ROWS);
  localparam int PAL_AW    = $clog2(PALETTE_WORDS);

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // Port offsets from the chip base.
  localparam logic [5:0] PORT_OAM_ADDR_LO  = 6'h02;
  localparam logic [5:0] PORT_OAM_ADDR_HI  = 6'h03;
  localparam logic [5:0] PORT_OAM_DATA     = 6'h04;
  localparam logic [5:0] PORT_VRAM_MODE    = 6'h15;
  localparam logic [5:0] PORT_VRAM_ADDR_LO = 6'h16;
  localparam logic [5:0] PORT_VRAM_ADDR_HI = 6'h17;
  localparam logic [5:0] PORT_VRAM_DATA_LO = 6'h18;
  localparam logic [5:0] PORT_VRAM_DATA_HI = 6'h19;
  localparam logic [5:0] PORT_CG_ADDR      = 6'h21;
  localparam logic [5:0] PORT_CG_DATA      = 6'h22;
  localparam logic [5:0] PORT_OAM_READ     = 6'h38;
  localparam logic [5:0] PORT_VRAM_READ_LO = 6'h39;
  localparam logic [5:0] PORT_VRAM_READ_HI = 6'h3a;
  localparam logic [5:0] PORT_CG_READ      = 6'h3b;

  // Address step selector in the video increment mode.
  localparam logic [1:0] STEP_ONE = 2'd0;
  localparam logic [1:0] STEP_32  = 2'd1;

  // Remap selector in the video increment mode.
  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_8    = 2'd1;
  localparam logic [1:0] REMAP_9    = 2'd2;

  typedef struct packed {
    logic              active;
    logic [VROW_W-1:0] addr;
  } clr_t;

  // Row of the video bank pair for a word address under the selected remap.
  function automatic logic [VROW_W-1:0] vmap_row(input logic [14:0] w,
                                                 input logic [1:0]  remap);
    logic [VROW_W-1:0] row;
    case (remap)
      REMAP_NONE: row = w;
      REMAP_8:    row = {w[14:8],  w[4:0], w[7:5]};
      REMAP_9:    row = {w[14:9],  w[5:0], w[8:6]};
      default:    row = {w[14:10], w[6:0], w[9:7]};
    endcase
    return row;
  endfunction

  function automatic logic [14:0] vmap_step(input logic [14:0] a,
                                            input logic [1:0]  sel);
    logic [14:0] n;
    case (sel)
      STEP_ONE: n = a + 15'd1;
      STEP_32:  n = a + 15'd32;
      default:  n = a + 15'd128;
    endcase
    return n;
  endfunction

  // Object RAM row; the high table folds to 0x200 + (addr & 0x1f).
  function automatic logic [OROW_W-1:0] oam_row(input logic [9:0] a);
    logic [OROW_W-1:0] row;
    if (a[9]) begin
      row = {1'b1, 4'b0000, a[4:1]};
    end else begin
      row = {1'b0, a[8:1]};
    end
    return row;
  endfunction

  // Swap the red and blue fields of a 15-bit color; bit 15 passes through.
  function automatic logic [15:0] rb_swap(input logic [15:0] c);
    return {c[15], c[4:0], c[9:5], c[14:10]};
  endfunction

  // Write-only ports: low nibble 4-6 or 8-a in the 0x0_, 0x1_ and 0x2_ rows.
  function automatic logic is_open_bus(input logic [5:0] p);
    return (p[5:4] != 2'b11) && (p[3] ^ p[2]) && (p[1:0] != 2'b11);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vmap_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read data.
`default_nettype none

module vmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/vmap_clear.sv =====
// Post-reset sweep that walks every memory row once to zero it.
`default_nettype none

module vmap_clear
  import vmap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  output clr_t      clr
);

  localparam logic [VROW_W-1:0] CLR_LAST = VROW_W'(VRAM_ROWS - 1);

  logic              act_r;
  logic              act_nxt;
  logic [VROW_W-1:0] cnt_r;
  logic [VROW_W-1:0] cnt_nxt;

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (act_r) begin
      cnt_nxt = cnt_r + VROW_W'(1);
      if (cnt_r == CLR_LAST) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign clr.active = act_r;
  assign clr.addr   = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/video_memory_access_ports_core.sv =====
// Top level: bus access ports to video, object and palette memories.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_cmd, in_port, in_write_data          | start high, busy low
//  result  | out_read_data                           | out_valid, one cycle
//
// One item per cycle while busy is low: the item is captured in the input
// register, and its result is registered and strobed on out_valid.
// Memory reads come from the previous cycle's registered RAM read, addressed
// by the updated port state, so consecutive items never wait on each other.
// After reset busy stays high while every memory row is zeroed, one row per cycle.
// The receiver cannot stall; results are not held.
`default_nettype none

module video_memory_access_ports_core
  import vmap_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_cmd,
  input  wire logic [5:0] in_port,
  input  wire logic [7:0] in_write_data,
  output logic            out_valid,
  output logic      [7:0] out_read_data
);

  clr_t clr;

  vmap_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  // Input register
  logic       in_v_r;
  logic       in_cmd_r;
  logic [5:0] in_port_r;
  logic [7:0] in_wd_r;

  // Port state
  logic [14:0] vaddr_r, vaddr_nxt;
  logic [7:0]  vmode_r, vmode_nxt;
  logic [15:0] pf_r, pf_nxt;
  logic        pf_pend_r, pf_pend_nxt;
  logic [9:0]  oaddr_r, oaddr_nxt;
  logic [7:0]  olow_r, olow_nxt;
  logic        ohigh_r, ohigh_nxt;
  logic [7:0]  olatch_r, olatch_nxt;
  logic [7:0]  paddr_r, paddr_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  platch_r, platch_nxt;
  logic [7:0]  ob1_r, ob1_nxt;
  logic [7:0]  ob2_r, ob2_nxt;
  logic        out_v_r;
  logic [7:0]  out_rd_r, out_rd_nxt;

  // Memory ports
  logic              vlo_we, vhi_we, vlo_we_m, vhi_we_m;
  logic [VROW_W-1:0] vrow_cur, vrow_rd, vram_wa;
  logic [7:0]        vram_wd;
  logic [7:0]        vlo_q, vhi_q;
  logic              oev_we, ood_we, oev_we_m, ood_we_m;
  logic [OROW_W-1:0] orow_wa, orow_rd, orow_wa_m;
  logic [7:0]        oev_wd, ood_wd, oev_wd_m, ood_wd_m;
  logic [7:0]        oev_q, ood_q;
  logic              pal_we, pal_we_m;
  logic [PAL_AW-1:0] pal_wa_m;
  logic [15:0]       pal_wd, pal_wd_m, pal_q, pal_c;

  logic [15:0] pf_cur;
  logic        oam_clr_row;

  assign busy   = clr.active;
  assign pf_cur = pf_pend_r ? {vhi_q, vlo_q} : pf_r;
  assign pal_c  = rb_swap(pal_q);

  always_comb begin
    vaddr_nxt   = vaddr_r;
    vmode_nxt   = vmode_r;
    pf_nxt      = pf_cur;
    pf_pend_nxt = 1'b0;
    oaddr_nxt   = oaddr_r;
    olow_nxt    = olow_r;
    ohigh_nxt   = ohigh_r;
    olatch_nxt  = olatch_r;
    paddr_nxt   = paddr_r;
    phase_nxt   = phase_r;
    platch_nxt  = platch_r;
    ob1_nxt     = ob1_r;
    ob2_nxt     = ob2_r;
    out_rd_nxt  = 8'd0;
    vrow_cur    = vmap_row(vaddr_r, vmode_r[3:2]);
    vlo_we      = 1'b0;
    vhi_we      = 1'b0;
    vram_wd     = in_wd_r;
    oev_we      = 1'b0;
    ood_we      = 1'b0;
    oev_wd      = in_wd_r;
    ood_wd      = in_wd_r;
    orow_wa     = oam_row(oaddr_r);
    pal_we      = 1'b0;
    pal_wd      = rb_swap({in_wd_r, platch_r});
    if (in_v_r) begin
      if (in_cmd_r == CMD_WRITE) begin
        case (in_port_r)
          PORT_OAM_ADDR_LO: begin
            olow_nxt  = in_wd_r;
            oaddr_nxt = {ohigh_r, in_wd_r, 1'b0};
          end
          PORT_OAM_ADDR_HI: begin
            ohigh_nxt = in_wd_r[0];
            oaddr_nxt = {in_wd_r[0], olow_r, 1'b0};
          end
          PORT_OAM_DATA: begin
            if (!oaddr_r[0]) begin
              olatch_nxt = in_wd_r;
            end
            if (!oaddr_r[9]) begin
              // low table: odd byte commits the latched even byte with it
              if (oaddr_r[0]) begin
                oev_we = 1'b1;
                oev_wd = olatch_r;
                ood_we = 1'b1;
              end
            end else if (oaddr_r[0]) begin
              ood_we = 1'b1;
            end else begin
              oev_we = 1'b1;
            end
            oaddr_nxt = oaddr_r + 10'd1;
          end
          PORT_VRAM_MODE: begin
            vmode_nxt = in_wd_r;
          end
          PORT_VRAM_ADDR_LO: begin
            vaddr_nxt   = {vaddr_r[14:8], in_wd_r};
            pf_pend_nxt = 1'b1;
          end
          PORT_VRAM_ADDR_HI: begin
            vaddr_nxt   = {in_wd_r[6:0], vaddr_r[7:0]};
            pf_pend_nxt = 1'b1;
          end
          PORT_VRAM_DATA_LO: begin
            vlo_we = 1'b1;
            if (!vmode_r[7]) begin
              vaddr_nxt = vmap_step(vaddr_r, vmode_r[1:0]);
            end
          end
          PORT_VRAM_DATA_HI: begin
            vhi_we = 1'b1;
            if (vmode_r[7]) begin
              vaddr_nxt = vmap_step(vaddr_r, vmode_r[1:0]);
            end
          end
          PORT_CG_ADDR: begin
            paddr_nxt = in_wd_r;
            phase_nxt = 1'b0;
          end
          PORT_CG_DATA: begin
            if (!phase_r) begin
              platch_nxt = in_wd_r;
            end else begin
              pal_we    = 1'b1;
              paddr_nxt = paddr_r + 8'd1;
            end
            phase_nxt = !phase_r;
          end
          default: begin
          end
        endcase
      end else begin
        case (in_port_r)
          PORT_OAM_READ: begin
            out_rd_nxt = oaddr_r[0] ? ood_q : oev_q;
            oaddr_nxt  = oaddr_r + 10'd1;
            ob1_nxt    = out_rd_nxt;
          end
          PORT_VRAM_READ_LO: begin
            out_rd_nxt = pf_cur[7:0];
            // refill from the current word before the advance
            if (!vmode_r[7]) begin
              pf_nxt    = {vhi_q, vlo_q};
              vaddr_nxt = vmap_step(vaddr_r, vmode_r[1:0]);
            end
            ob1_nxt = out_rd_nxt;
          end
          PORT_VRAM_READ_HI: begin
            out_rd_nxt = pf_cur[15:8];
            if (vmode_r[7]) begin
              pf_nxt    = {vhi_q, vlo_q};
              vaddr_nxt = vmap_step(vaddr_r, vmode_r[1:0]);
            end
            ob1_nxt = out_rd_nxt;
          end
          PORT_CG_READ: begin
            if (phase_r) begin
              out_rd_nxt = {pal_c[15] | ob2_r[7], pal_c[14:8]};
              paddr_nxt  = paddr_r + 8'd1;
            end else begin
              out_rd_nxt = pal_c[7:0];
            end
            phase_nxt = !phase_r;
            ob2_nxt   = out_rd_nxt;
          end
          default: begin
            out_rd_nxt = is_open_bus(in_port_r) ? ob1_r : 8'd0;
          end
        endcase
      end
    end
  end

  // Read addresses follow the updated state so the next item finds its data.
  assign vrow_rd = vmap_row(vaddr_nxt, vmode_nxt[3:2]);
  assign orow_rd = oam_row(oaddr_nxt);

  // Clear sweep takes over the write ports until it is done.
  assign oam_clr_row = (clr.addr < VROW_W'(OAM_ROWS));
  assign vlo_we_m    = clr.active | vlo_we;
  assign vhi_we_m    = clr.active | vhi_we;
  assign vram_wa     = clr.active ? clr.addr : vrow_cur;
  assign oev_we_m    = clr.active ? oam_clr_row : oev_we;
  assign ood_we_m    = clr.active ? oam_clr_row : ood_we;
  assign orow_wa_m   = clr.active ? clr.addr[OROW_W-1:0] : orow_wa;
  assign oev_wd_m    = clr.active ? 8'd0 : oev_wd;
  assign ood_wd_m    = clr.active ? 8'd0 : ood_wd;
  assign pal_we_m    = clr.active ? (clr.addr[VROW_W-1:PAL_AW] == '0) : pal_we;
  assign pal_wa_m    = clr.active ? clr.addr[PAL_AW-1:0] : paddr_r;
  assign pal_wd_m    = clr.active ? 16'd0 : pal_wd;

  vmap_ram #(.WIDTH(8), .DEPTH(VRAM_ROWS)) u_vram_lo (
    .clk   (clk),
    .we    (vlo_we_m),
    .waddr (vram_wa),
    .wdata (clr.active ? 8'd0 : vram_wd),
    .raddr (vrow_rd),
    .rdata (vlo_q)
  );

  vmap_ram #(.WIDTH(8), .DEPTH(VRAM_ROWS)) u_vram_hi (
    .clk   (clk),
    .we    (vhi_we_m),
    .waddr (vram_wa),
    .wdata (clr.active ? 8'd0 : vram_wd),
    .raddr (vrow_rd),
    .rdata (vhi_q)
  );

  vmap_ram #(.WIDTH(8), .DEPTH(OAM_ROWS)) u_oam_ev (
    .clk   (clk),
    .we    (oev_we_m),
    .waddr (orow_wa_m),
    .wdata (oev_wd_m),
    .raddr (orow_rd),
    .rdata (oev_q)
  );

  vmap_ram #(.WIDTH(8), .DEPTH(OAM_ROWS)) u_oam_od (
    .clk   (clk),
    .we    (ood_we_m),
    .waddr (orow_wa_m),
    .wdata (ood_wd_m),
    .raddr (orow_rd),
    .rdata (ood_q)
  );

  vmap_ram #(.WIDTH(16), .DEPTH(PALETTE_WORDS)) u_pal (
    .clk   (clk),
    .we    (pal_we_m),
    .waddr (pal_wa_m),
    .wdata (pal_wd_m),
    .raddr (paddr_nxt),
    .rdata (pal_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      vaddr_r   <= '0;
      vmode_r   <= '0;
      pf_r      <= '0;
      pf_pend_r <= 1'b0;
      oaddr_r   <= '0;
      olow_r    <= '0;
      ohigh_r   <= 1'b0;
      olatch_r  <= '0;
      paddr_r   <= '0;
      phase_r   <= 1'b0;
      platch_r  <= '0;
      ob1_r     <= '0;
      ob2_r     <= '0;
      out_v_r   <= 1'b0;
    end else begin
      in_v_r    <= start && !busy;
      vaddr_r   <= vaddr_nxt;
      vmode_r   <= vmode_nxt;
      pf_r      <= pf_nxt;
      pf_pend_r <= pf_pend_nxt;
      oaddr_r   <= oaddr_nxt;
      olow_r    <= olow_nxt;
      ohigh_r   <= ohigh_nxt;
      olatch_r  <= olatch_nxt;
      paddr_r   <= paddr_nxt;
      phase_r   <= phase_nxt;
      platch_r  <= platch_nxt;
      ob1_r     <= ob1_nxt;
      ob2_r     <= ob2_nxt;
      out_v_r   <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd_r  <= in_cmd;
      in_port_r <= in_port;
      in_wd_r   <= in_write_data;
    end
    out_rd_r <= out_rd_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_read_data = out_rd_r;

endmodule

`default_nettype wire

// ===== rtl/vmap_checker.sv =====
// Port-level checks of the video memory access ports, bound to the top level.
`default_nettype none

module vmap_checker
  import vmap_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_cmd,
  input wire logic [5:0] in_port,
  input wire logic       out_valid,
  input wire logic [7:0] out_read_data
);

  // Every accepted item yields exactly one strobe, once it has passed the input register and the result register.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2)) |-> (out_valid == $past(start && !busy, 2)))
    else $error("result strobe does not match accepted item");

  // Writes return zero.
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2) && $past(start && !busy && in_cmd == CMD_WRITE, 2))
    |-> (out_read_data == 8'd0))
    else $error("write item returned nonzero data");

  // Ports below object data are never readable.
  a_low_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2)
     && $past(start && !busy && in_cmd == CMD_READ && in_port < PORT_OAM_DATA, 2))
    |-> (out_read_data == 8'd0))
    else $error("read of an unhandled port returned data");

  // Once the clear sweep ends, busy stays low.
  a_busy_falls_once: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(busy)) |-> !busy)
    else $error("busy rose again after the clear sweep");

endmodule

bind video_memory_access_ports_core vmap_checker u_vmap_checker (.*);

`default_nettype wire
